[rtl/core/vcs_pkg.sv]
// ============================================================================
// vcs_pkg: shared constants and types of the vector clock snapshot unit
// Request and result codes, widths, lane control and status records, and the
// result record that waits in the output queue.
// ============================================================================
package vcs_pkg;

    localparam int NODE_COUNT    = 3;
    localparam int CHANNEL_DEPTH = 64;
    localparam int ENTRIES       = 3;

    localparam int CLOCK_W  = 16;
    localparam int RANK_W   = 2;
    localparam int KIND_W   = 3;
    localparam int RKIND_W  = 2;
    localparam int FILL_W   = $clog2(CHANNEL_DEPTH + 1);
    localparam int STORE_DEPTH  = NODE_COUNT * CHANNEL_DEPTH;
    localparam int STORE_ADDR_W = $clog2(STORE_DEPTH);
    localparam int STORE_W  = ENTRIES * CLOCK_W;

    localparam logic [CLOCK_W-1:0] CLOCK_MAX = {CLOCK_W{1'b1}};
    localparam bit PAIR_MARKERS = (NODE_COUNT > 2);

    // request kinds
    localparam logic [KIND_W-1:0] KIND_LOCAL   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_SEND    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RECV    = 3'd2;
    localparam logic [KIND_W-1:0] KIND_START   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ARRIVAL = 3'd4;
    localparam logic [KIND_W-1:0] KIND_MARKER  = 3'd5;

    // result kinds
    localparam logic [RKIND_W-1:0] RES_REPORT  = 2'd0;
    localparam logic [RKIND_W-1:0] RES_MESSAGE = 2'd1;
    localparam logic [RKIND_W-1:0] RES_MARKER  = 2'd2;
    localparam logic [RKIND_W-1:0] RES_STATUS  = 2'd3;

    typedef logic [ENTRIES-1:0][CLOCK_W-1:0] vcs_clock_t;

    typedef struct packed {
        logic              accept;
        logic [KIND_W-1:0] kind;
        logic [RANK_W-1:0] peer;
        logic [RANK_W-1:0] own_rank;
        logic              snap_taken;
        logic              snap_start;
    } vcs_lane_ctl_t;

    typedef struct packed {
        logic [CLOCK_W-1:0] clock_next;
        logic               store_hit;
        logic               store_full;
        logic [FILL_W-1:0]  fill;
    } vcs_lane_st_t;

    typedef struct packed {
        logic [RKIND_W-1:0] rkind;
        logic [RANK_W-1:0]  dest;
        logic [RANK_W-1:0]  dest2;
        vcs_clock_t         clock;
        logic               saved;
        logic               ovf;
        logic               pair;
    } vcs_rec_t;

endpackage

[rtl/core/vcs_req_if.sv]
// ============================================================================
// vcs_req_if: request channel
// Valid/ready channel carrying one request of the vector clock unit.
// ============================================================================
interface vcs_req_if import vcs_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [RANK_W-1:0]  peer_rank;
    logic [CLOCK_W-1:0] msg_clock_0;
    logic [CLOCK_W-1:0] msg_clock_1;
    logic [CLOCK_W-1:0] msg_clock_2;

    modport source (output valid, kind, peer_rank, msg_clock_0, msg_clock_1, msg_clock_2,
                    input ready);
    modport sink (input valid, kind, peer_rank, msg_clock_0, msg_clock_1, msg_clock_2,
                  output ready);

endinterface

[rtl/core/vcs_rsp_if.sv]
// ============================================================================
// vcs_rsp_if: result channel
// Valid/ready channel carrying one result item of the vector clock unit.
// ============================================================================
interface vcs_rsp_if import vcs_pkg::*; ();

    logic               valid;
    logic               ready;
    logic [RKIND_W-1:0] result_kind;
    logic [RANK_W-1:0]  dest_rank;
    logic [CLOCK_W-1:0] clock_out_0;
    logic [CLOCK_W-1:0] clock_out_1;
    logic [CLOCK_W-1:0] clock_out_2;
    logic               in_transit_saved;
    logic               store_overflow;
    logic               last;

    modport source (output valid, result_kind, dest_rank, clock_out_0, clock_out_1,
                    clock_out_2, in_transit_saved, store_overflow, last,
                    input ready);
    modport sink (input valid, result_kind, dest_rank, clock_out_0, clock_out_1,
                  clock_out_2, in_transit_saved, store_overflow, last,
                  output ready);

endinterface

[rtl/core/vcs_ram.sv]
// ============================================================================
// vcs_ram: generic single-port-write RAM
// One write port, one read port with registered read data.
// ============================================================================
module vcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[rtl/core/vcs_lane.sv]
// ============================================================================
// vcs_lane: one clock entry and its incoming channel
// Holds one entry of the local clock plus the closed flag and fill count of
// the channel from the node of the same rank.
// ============================================================================
module vcs_lane import vcs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [RANK_W-1:0]  lane_rank,
    input  vcs_lane_ctl_t      ctl,
    input  logic [CLOCK_W-1:0] msg,
    output vcs_lane_st_t       st
);

    logic [CLOCK_W-1:0] clock_reg;
    logic [CLOCK_W-1:0] clock_next;
    logic               closed_reg;
    logic               closed_next;
    logic [FILL_W-1:0]  fill_reg;
    logic [FILL_W-1:0]  fill_next;

    logic               active;
    logic               is_own;
    logic               bump;
    logic               peer_hit;
    logic               open_hit;
    logic               has_room;
    logic [CLOCK_W-1:0] merged;

    always_comb
    begin
        active   = (lane_rank < RANK_W'(NODE_COUNT));
        is_own   = (lane_rank == ctl.own_rank);
        merged   = (active && ctl.kind == KIND_RECV && msg > clock_reg) ? msg : clock_reg;
        bump     = is_own && (ctl.kind inside {KIND_LOCAL, KIND_SEND, KIND_RECV});
        clock_next = (bump && merged != CLOCK_MAX) ? merged + CLOCK_W'(1) : merged;

        peer_hit = active && !is_own && (ctl.peer == lane_rank);
        open_hit = ctl.snap_taken && peer_hit && !closed_reg && (ctl.kind == KIND_ARRIVAL);
        has_room = (fill_reg < FILL_W'(CHANNEL_DEPTH));

        // reopen on the save, then a marker from this peer closes it again
        if (ctl.kind == KIND_MARKER && peer_hit)
            closed_next = 1'b1;
        else if (ctl.snap_start && !is_own)
            closed_next = 1'b0;
        else
            closed_next = closed_reg;

        if (open_hit && has_room)
            fill_next = fill_reg + FILL_W'(1);
        else if (ctl.snap_start && !is_own)
            fill_next = '0;
        else
            fill_next = fill_reg;

        st.clock_next = clock_next;
        st.store_hit  = open_hit && has_room;
        st.store_full = open_hit && !has_room;
        st.fill       = fill_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_reg  <= '0;
            closed_reg <= 1'b0;
            fill_reg   <= '0;
        end
        else if (ctl.accept)
        begin
            clock_reg  <= clock_next;
            closed_reg <= closed_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

[rtl/core/vcs_merge.sv]
// ============================================================================
// vcs_merge: lane merge
// Combines the lane results into one result record and the channel store
// write for the current request.
// ============================================================================
module vcs_merge import vcs_pkg::*; (
    input  vcs_lane_ctl_t                   ctl,
    input  vcs_lane_st_t [ENTRIES-1:0]      lane_st,
    input  vcs_clock_t                      msg,
    output vcs_rec_t                        rec,
    output logic                            store_we,
    output logic [STORE_ADDR_W-1:0]         store_addr,
    output logic [STORE_W-1:0]              store_data
);

    logic hit_any;
    logic full_any;

    always_comb
    begin
        hit_any    = 1'b0;
        full_any   = 1'b0;
        store_addr = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_any  = hit_any | lane_st[i].store_hit;
            full_any = full_any | lane_st[i].store_full;
            if (lane_st[i].store_hit)
                store_addr = STORE_ADDR_W'(i * CHANNEL_DEPTH)
                           + STORE_ADDR_W'(lane_st[i].fill);
        end
        store_we = ctl.accept && hit_any;

        for (int i = 0; i < ENTRIES; i++)
        begin
            rec.clock[i]   = lane_st[i].clock_next;
            store_data[i*CLOCK_W +: CLOCK_W] = (i < NODE_COUNT) ? msg[i] : '0;
        end

        rec.rkind = RES_REPORT;
        rec.dest  = '0;
        rec.dest2 = '0;
        rec.saved = 1'b0;
        rec.ovf   = 1'b0;
        rec.pair  = 1'b0;

        if (ctl.snap_start)
        begin
            // markers go to every other node in rising rank order
            rec.rkind = RES_MARKER;
            rec.dest  = (ctl.own_rank == '0) ? RANK_W'(1) : RANK_W'(0);
            rec.dest2 = (ctl.own_rank == RANK_W'(2)) ? RANK_W'(1) : RANK_W'(2);
            rec.pair  = PAIR_MARKERS;
        end
        else
        begin
            case (ctl.kind)
                KIND_SEND:
                begin
                    rec.rkind = RES_MESSAGE;
                    rec.dest  = ctl.peer;
                end
                KIND_ARRIVAL:
                begin
                    rec.rkind = RES_STATUS;
                    rec.saved = hit_any;
                    rec.ovf   = full_any;
                end
                KIND_MARKER:
                begin
                    rec.rkind = RES_STATUS;
                end
                default:
                begin
                    rec.rkind = RES_REPORT;
                end
            endcase
        end
    end

endmodule

[rtl/core/vcs_outq.sv]
// ============================================================================
// vcs_outq: result queue
// Two-record queue in front of the result channel; a marker record is sent as
// two result items.
// ============================================================================
module vcs_outq import vcs_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    input  vcs_rec_t     push_rec,
    output logic         push_ready,
    vcs_rsp_if.source    response
);

    vcs_rec_t   rec_q [2];
    logic       head_reg;
    logic       head_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       phase_reg;
    logic       phase_next;

    vcs_rec_t   head;
    logic       push;
    logic       pop_fire;
    logic       item_done;
    logic       tail;

    always_comb
    begin
        head       = rec_q[head_reg];
        push_ready = (count_reg != 2'd2);
        push       = push_valid && push_ready;
        tail       = head_reg ^ count_reg[0];

        response.valid            = (count_reg != 2'd0);
        response.result_kind      = head.rkind;
        response.dest_rank        = phase_reg ? head.dest2 : head.dest;
        response.clock_out_0      = head.clock[0];
        response.clock_out_1      = head.clock[1];
        response.clock_out_2      = head.clock[2];
        response.in_transit_saved = head.saved;
        response.store_overflow   = head.ovf;
        response.last             = !head.pair || phase_reg;

        pop_fire  = response.valid && response.ready;
        item_done = pop_fire && (!head.pair || phase_reg);

        head_next  = item_done ? ~head_reg : head_reg;
        phase_next = pop_fire ? !item_done : phase_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, item_done};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rec_q[tail] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= 1'b0;
            count_reg <= 2'd0;
            phase_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            phase_reg <= phase_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("result queue count out of range");

    a_phase_pair: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (head.pair && count_reg != 2'd0))
        else $error("second item phase without a pending marker record");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg && !response.ready) |=> phase_reg)
        else $error("second marker item lost while stalled");
`endif

endmodule

[rtl/core/vector_clock_snapshot_unit.sv]
// ============================================================================
// vector_clock_snapshot_unit: vector clock with snapshot support
// Keeps one node's vector clock in three parallel lanes, takes the snapshot
// on a start request or the first marker, and records in-transit messages
// per incoming channel.
// ============================================================================
// Results: the first result item of a request comes from the result queue
//   register, behind any records still waiting there.
// Throughput: one request per cycle; a snapshot save gives two marker items from one
//   queue record; request ready drops while both queue records are full.
// Reset: asynchronous, active low; clears clock, snapshot flag, channel flags,
//   fill counts, node_rank and the queue. The channel store is not cleared.
module vector_clock_snapshot_unit import vcs_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [RANK_W-1:0]  cfg_wr_data,
    vcs_req_if.sink            request,
    vcs_rsp_if.source          response
);

    logic [RANK_W-1:0] node_rank_reg;
    logic              snap_taken_reg;
    logic              snap_taken_next;

    logic              accept;
    logic              push_ready;
    logic [RANK_W-1:0] own_rank;
    logic              snap_start;
    vcs_clock_t        msg;

    vcs_lane_ctl_t              ctl;
    vcs_lane_st_t [ENTRIES-1:0] lane_st;
    vcs_rec_t                   rec;

    logic                    store_we;
    logic [STORE_ADDR_W-1:0] store_addr;
    logic [STORE_W-1:0]      store_data;

    // A rank past the last node acts as the last node.
    assign own_rank = (node_rank_reg < RANK_W'(NODE_COUNT)) ? node_rank_reg
                                                           : RANK_W'(NODE_COUNT - 1);

    // Accept while the queue has a free record slot; the result side may stall.
    assign request.ready = push_ready;
    assign accept        = request.valid && request.ready;

    // The save happens on a start request or on any marker before the save.
    assign snap_start = !snap_taken_reg
                      && (request.kind == KIND_START || request.kind == KIND_MARKER);
    assign snap_taken_next = snap_taken_reg || (accept && snap_start);

    assign msg[0] = request.msg_clock_0;
    assign msg[1] = request.msg_clock_1;
    assign msg[2] = request.msg_clock_2;

    always_comb
    begin
        ctl.accept     = accept;
        ctl.kind       = request.kind;
        ctl.peer       = request.peer_rank;
        ctl.own_rank   = own_rank;
        ctl.snap_taken = snap_taken_reg;
        ctl.snap_start = snap_start;
    end

    // One lane per clock entry: merge, increment and channel bookkeeping.
    for (genvar g = 0; g < ENTRIES; g++)
    begin : g_lane
        vcs_lane u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .lane_rank (RANK_W'(g)),
            .ctl       (ctl),
            .msg       (msg[g]),
            .st        (lane_st[g])
        );
    end

    // Combine the lanes into the result record and the store write.
    vcs_merge u_merge (
        .ctl        (ctl),
        .lane_st    (lane_st),
        .msg        (msg),
        .rec        (rec),
        .store_we   (store_we),
        .store_addr (store_addr),
        .store_data (store_data)
    );

    // In-transit messages, one region of CHANNEL_DEPTH records per sender.
    vcs_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (store_we),
        .wr_addr (store_addr),
        .wr_data (store_data),
        .rd_addr (store_addr),
        .rd_data ()
    );

    // Hold finished records until the result side takes them.
    vcs_outq u_outq (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (request.valid),
        .push_rec   (rec),
        .push_ready (push_ready),
        .response   (response)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_rank_reg  <= '0;
            snap_taken_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                node_rank_reg <= cfg_wr_data;
            end
            snap_taken_reg <= snap_taken_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_store_after_save: assert property (@(posedge clk) disable iff (!rst_n)
        store_we |-> snap_taken_reg)
        else $error("channel store written before the snapshot was taken");

    a_save_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.kind == KIND_START) |=> snap_taken_reg)
        else $error("snapshot flag not set after a start request");

    a_save_holds: assert property (@(posedge clk) disable iff (!rst_n)
        snap_taken_reg |=> snap_taken_reg)
        else $error("snapshot flag cleared without a reset");
`endif

endmodule

[dv/vector_clock_snapshot_unit_test.sv]
// ============================================================================
// vector_clock_snapshot_unit_test: request/result check of the vector clock
// Drives requests into the vector clock snapshot unit, tracks the clock,
// snapshot and channel state alongside it, and compares every result item
// field by field against the predicted sequence.
// ============================================================================
module vector_clock_snapshot_unit_test;

    import vcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Kind codes that the block treats as no-ops
    localparam logic [KIND_W-1:0] KIND_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_7 = 3'd7;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_ITEMS   = 400;
    localparam int HOLD_OFF_LEN  = 300;

    typedef struct packed {
        logic [RKIND_W-1:0] rkind;
        logic [RANK_W-1:0]  dest;
        logic [CLOCK_W-1:0] c0;
        logic [CLOCK_W-1:0] c1;
        logic [CLOCK_W-1:0] c2;
        logic               saved;
        logic               ovf;
        logic               last;
    } clock_result_t;

    // ------------------------------------------------------------------------
    // Clock state tracker: mirrors the node's clock, snapshot flag, channel
    // flags and fill counts, and holds the result items still to come.
    // ------------------------------------------------------------------------
    class vclock_tracker;
        logic [RANK_W-1:0]  rank_reg;
        logic [CLOCK_W-1:0] vclock [ENTRIES];
        bit                 snap_seen;
        bit                 chan_closed [ENTRIES];
        int unsigned        chan_fill [ENTRIES];
        clock_result_t      pending_results [$];
        int unsigned        mismatches;

        function new();
            rank_reg   = '0;
            snap_seen  = 1'b0;
            mismatches = 0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                vclock[i]      = '0;
                chan_closed[i] = 1'b0;
                chan_fill[i]   = 0;
            end
        endfunction

        function void set_rank(logic [RANK_W-1:0] value);
            rank_reg = value;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function int unsigned own_rank();
            return (rank_reg < NODE_COUNT) ? int'(rank_reg) : NODE_COUNT - 1;
        endfunction

        function void bump_own();
            int unsigned r;
            r = own_rank();
            if (vclock[r] != CLOCK_MAX)
                vclock[r] = vclock[r] + 1'b1;
        endfunction

        function void push_result(logic [RKIND_W-1:0] rkind, logic [RANK_W-1:0] dest,
                                  logic saved, logic ovf, logic last);
            clock_result_t r;
            r.rkind = rkind;
            r.dest  = dest;
            r.c0    = vclock[0];
            r.c1    = vclock[1];
            r.c2    = vclock[2];
            r.saved = saved;
            r.ovf   = ovf;
            r.last  = last;
            pending_results.push_back(r);
        endfunction

        // Save the clock, reopen the other channels, one marker per other node
        function void save_snapshot();
            int unsigned r;
            int          final_dest;
            r = own_rank();
            snap_seen  = 1'b1;
            final_dest = -1;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                if (i != r)
                begin
                    chan_closed[i] = 1'b0;
                    chan_fill[i]   = 0;
                    final_dest     = i;
                end
            end
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                if (i != r)
                    push_result(RES_MARKER, RANK_W'(i), 1'b0, 1'b0, i == final_dest);
            end
        endfunction

        function void note_request(logic [KIND_W-1:0] kind, logic [RANK_W-1:0] peer,
                                   logic [CLOCK_W-1:0] m0, logic [CLOCK_W-1:0] m1,
                                   logic [CLOCK_W-1:0] m2);
            logic [CLOCK_W-1:0] msg [ENTRIES];
            bit                 chan_ok;
            logic               saved;
            logic               ovf;
            msg[0]  = m0;
            msg[1]  = m1;
            msg[2]  = m2;
            chan_ok = (peer < NODE_COUNT) && (int'(peer) != own_rank());
            saved   = 1'b0;
            ovf     = 1'b0;
            case (kind)
                KIND_LOCAL:
                begin
                    bump_own();
                    push_result(RES_REPORT, '0, 1'b0, 1'b0, 1'b1);
                end
                KIND_SEND:
                begin
                    bump_own();
                    push_result(RES_MESSAGE, peer, 1'b0, 1'b0, 1'b1);
                end
                KIND_RECV:
                begin
                    for (int i = 0; i < NODE_COUNT; i++)
                        if (msg[i] > vclock[i])
                            vclock[i] = msg[i];
                    bump_own();
                    push_result(RES_REPORT, '0, 1'b0, 1'b0, 1'b1);
                end
                KIND_START:
                begin
                    if (snap_seen)
                        push_result(RES_REPORT, '0, 1'b0, 1'b0, 1'b1);
                    else
                        save_snapshot();
                end
                KIND_ARRIVAL:
                begin
                    if (snap_seen && chan_ok && !chan_closed[peer])
                    begin
                        if (chan_fill[peer] < CHANNEL_DEPTH)
                        begin
                            chan_fill[peer]++;
                            saved = 1'b1;
                        end
                        else
                            ovf = 1'b1;
                    end
                    push_result(RES_STATUS, '0, saved, ovf, 1'b1);
                end
                KIND_MARKER:
                begin
                    if (!snap_seen)
                    begin
                        save_snapshot();
                        if (chan_ok)
                            chan_closed[peer] = 1'b1;
                    end
                    else
                    begin
                        if (chan_ok)
                            chan_closed[peer] = 1'b1;
                        push_result(RES_STATUS, '0, 1'b0, 1'b0, 1'b1);
                    end
                end
                default:
                    push_result(RES_REPORT, '0, 1'b0, 1'b0, 1'b1);
            endcase
        endfunction

        function void field_check(string name, logic [CLOCK_W-1:0] expected,
                                  logic [CLOCK_W-1:0] actual);
            if (actual !== expected)
            begin
                $error("%s: expected %0h, got %0h", name, expected, actual);
                mismatches++;
            end
        endfunction

        function void check_result(clock_result_t got);
            clock_result_t want;
            if (pending_results.size() == 0)
            begin
                $error("result item with nothing outstanding: kind %0d", got.rkind);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            field_check("result_kind", want.rkind, got.rkind);
            field_check("dest_rank", want.dest, got.dest);
            field_check("clock_out_0", want.c0, got.c0);
            field_check("clock_out_1", want.c1, got.c1);
            field_check("clock_out_2", want.c2, got.c2);
            field_check("in_transit_saved", want.saved, got.saved);
            field_check("store_overflow", want.ovf, got.ovf);
            field_check("last", want.last, got.last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic              clk = 1'b0;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [RANK_W-1:0] cfg_wr_data;

    vcs_req_if req_bus ();
    vcs_rsp_if rsp_bus ();

    vclock_tracker tracker;

    // Idle rates in percent per side, and the receiver hold-off length
    int req_idle_pct = 30;
    int rsp_idle_pct = 30;
    int hold_cycles  = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    vector_clock_snapshot_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .request     (req_bus.sink),
        .response    (rsp_bus.source)
    );

    // ------------------------------------------------------------------------
    // Request driver. After a call returns, the caller must in the same time
    // step either offer the next request or drop valid, so that valid gets
    // exactly one update per edge.
    // ------------------------------------------------------------------------
    task automatic send_request(logic [KIND_W-1:0] kind, logic [RANK_W-1:0] peer,
                                logic [CLOCK_W-1:0] m0, logic [CLOCK_W-1:0] m1,
                                logic [CLOCK_W-1:0] m2);
        // Insert random idle cycles ahead of the request
        while ($urandom_range(0, 99) < req_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.kind        <= kind;
        req_bus.peer_rank   <= peer;
        req_bus.msg_clock_0 <= m0;
        req_bus.msg_clock_1 <= m1;
        req_bus.msg_clock_2 <= m2;
        // Hold the request until the block takes it
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        tracker.note_request(kind, peer, m0, m1, m2);
    endtask

    task automatic stop_requests();
        req_bus.valid <= 1'b0;
    endtask

    // Wait until every predicted result has come back, then let the pipe settle
    task automatic drain_results();
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write node_rank only with the block idle
    task automatic write_rank(logic [RANK_W-1:0] value);
        drain_results();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        tracker.set_rank(value);
    endtask

    // ------------------------------------------------------------------------
    // Random phase. Arrivals dominate so that the open channels fill up and
    // overflow; markers are kept rare because each one closes a channel for
    // good. Most arrivals name the favored peer. With wide_recv set, merges
    // use full-range clocks with frequent extremes, which saturates entries.
    // ------------------------------------------------------------------------
    task automatic run_phase(int count, int marker_pct, logic [RANK_W-1:0] fav_peer,
                             bit wide_recv);
        int                 roll;
        logic [KIND_W-1:0]  kind;
        logic [RANK_W-1:0]  peer;
        logic [CLOCK_W-1:0] msg [ENTRIES];
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(0, 99);
            if (roll < marker_pct)
                kind = KIND_MARKER;
            else if (roll < marker_pct + 40)
                kind = KIND_ARRIVAL;
            else if (roll < marker_pct + 52)
                kind = KIND_LOCAL;
            else if (roll < marker_pct + 64)
                kind = KIND_SEND;
            else if (roll < marker_pct + 80)
                kind = KIND_RECV;
            else if (roll < marker_pct + 85)
                kind = KIND_START;
            else if (roll < marker_pct + 90)
                kind = $urandom_range(0, 1) ? KIND_SPARE_6 : KIND_SPARE_7;
            else
                kind = KIND_ARRIVAL;
            peer = ($urandom_range(0, 99) < 65) ? fav_peer : RANK_W'($urandom_range(0, 3));
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (kind != KIND_RECV)
                    msg[i] = CLOCK_W'($urandom);
                else if (!wide_recv)
                    msg[i] = CLOCK_W'($urandom_range(0, 4000));
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       msg[i] = '0;
                        1:       msg[i] = CLOCK_MAX;
                        default: msg[i] = CLOCK_W'($urandom);
                    endcase
                end
            end
            send_request(kind, peer, msg[0], msg[1], msg[2]);
        end
        stop_requests();
    endtask

    // ------------------------------------------------------------------------
    // Result sink: check every accepted result, then pick the next ready.
    // A pending hold-off keeps ready low for its full length, counted here.
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        clock_result_t got;
        rsp_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && rsp_bus.valid && rsp_bus.ready)
            begin
                got.rkind = rsp_bus.result_kind;
                got.dest  = rsp_bus.dest_rank;
                got.c0    = rsp_bus.clock_out_0;
                got.c1    = rsp_bus.clock_out_1;
                got.c2    = rsp_bus.clock_out_2;
                got.saved = rsp_bus.in_transit_saved;
                got.ovf   = rsp_bus.store_overflow;
                got.last  = rsp_bus.last;
                tracker.check_result(got);
            end
            if (hold_cycles > 0)
            begin
                rsp_bus.ready <= 1'b0;
                hold_cycles--;
            end
            else
                rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
        end
    end

    // Abort a hung run
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("vector_clock_snapshot_unit_test: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin : main_flow
        tracker = new();

        // Drive every input to a known value and hold reset
        rst_n               <= 1'b0;
        cfg_wr_en           <= 1'b0;
        cfg_wr_data         <= '0;
        req_bus.valid       <= 1'b0;
        req_bus.kind        <= KIND_LOCAL;
        req_bus.peer_rank   <= '0;
        req_bus.msg_clock_0 <= '0;
        req_bus.msg_clock_1 <= '0;
        req_bus.msg_clock_2 <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset rank 0, starting before any snapshot
        send_request(KIND_LOCAL, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        send_request(KIND_SEND, 2'd1, 16'h0000, 16'h0000, 16'h0000);
        // Send to a rank that names no node, and to this node itself
        send_request(KIND_SEND, 2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_SEND, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        // Merge with an all-zero clock, then with one ahead of ours in entries 1 and 2
        send_request(KIND_RECV, 2'd1, 16'h0000, 16'h0000, 16'h0000);
        send_request(KIND_RECV, 2'd2, 16'h0001, 16'h0123, 16'h0456);
        // Arrival before any snapshot: never stored
        send_request(KIND_ARRIVAL, 2'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_SPARE_6, 2'd2, 16'hAAAA, 16'h5555, 16'hFFFF);
        send_request(KIND_SPARE_7, 2'd3, 16'h5555, 16'hAAAA, 16'h0000);
        // First marker from node 1: take the snapshot and close its channel
        send_request(KIND_MARKER, 2'd1, 16'h1234, 16'h5678, 16'h9ABC);
        // Arrival on the closed channel, on the open one, from self, from nowhere
        send_request(KIND_ARRIVAL, 2'd1, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_request(KIND_ARRIVAL, 2'd2, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_ARRIVAL, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        send_request(KIND_ARRIVAL, 2'd3, 16'h8001, 16'h8001, 16'h8001);
        // Snapshot already taken: start only reports the clock
        send_request(KIND_START, 2'd0, 16'h0000, 16'h0000, 16'h0000);
        // Later markers from nowhere and from self close nothing
        send_request(KIND_MARKER, 2'd3, 16'h0000, 16'h0000, 16'h0000);
        send_request(KIND_MARKER, 2'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_request(KIND_ARRIVAL, 2'd2, 16'h7FFF, 16'h8000, 16'h0001);
        send_request(KIND_RECV, 2'd1, 16'h0100, 16'h0200, 16'h0300);
        send_request(KIND_LOCAL, 2'd3, 16'h0000, 16'h0000, 16'h0000);
        stop_requests();

        // Rank 0, channel 2 open: fill it past its depth. Stall the receiver
        // for a long stretch up front so the result queue backs up into the
        // request side.
        write_rank(2'd0);
        hold_cycles = HOLD_OFF_LEN;
        run_phase(PHASE_ITEMS, 0, 2'd2, 1'b0);

        // Out-of-range rank acts as rank 2; channel 0 was never reset by the
        // snapshot and is open. Run this phase with no idling on either side.
        write_rank(2'd3);
        req_idle_pct = 0;
        rsp_idle_pct = 0;
        run_phase(PHASE_ITEMS, 0, 2'd0, 1'b0);

        // Back to random idling; a few markers now start closing channels
        write_rank(2'd1);
        req_idle_pct = 30;
        rsp_idle_pct = 30;
        hold_cycles  = HOLD_OFF_LEN;
        run_phase(PHASE_ITEMS, 3, 2'd2, 1'b0);

        write_rank(2'd2);
        run_phase(PHASE_ITEMS, 3, 2'd0, 1'b0);

        // Full-range merges drive entries to the top and hold them there
        write_rank(2'd0);
        run_phase(PHASE_ITEMS, 2, 2'd2, 1'b1);

        // Wait out every remaining result, then report
        drain_results();
        if (tracker.mismatches == 0)
            $display("vector_clock_snapshot_unit_test: done, clean");
        else
            $display("vector_clock_snapshot_unit_test: done, errors");
        $finish;
    end

endmodule
